// ===== sv/assert_macros.svh =====
// Shared assertion macros for the key debounce block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`endif

// ===== sv/kdpc_pkg.sv =====
package kdpc_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW = 2'd2;

	localparam logic [CFG_W-1:0] DEBOUNCE_TICKS_RST = 16'd50;
	localparam logic [CFG_W-1:0] LONG_PRESS_TICKS_RST = 16'd1000;
	localparam logic ACTIVE_LOW_RST = 1'b1;

	typedef enum logic [1:0] {
		ST_UNINIT = 2'd0,
		ST_RELEASED = 2'd1,
		ST_PRESSED = 2'd2
	} kdpc_state_t;

	typedef enum logic [1:0] {
		PH_NONE = 2'd0,
		PH_BEGIN = 2'd1,
		PH_LONG = 2'd2
	} kdpc_phase_t;

	// Debounced state before and after the current request.
	typedef struct packed {
		kdpc_state_t cur;
		kdpc_state_t nxt;
	} kdpc_deb_t;

endpackage

// ===== sv/key_debounce_press_classifier_unit.sv =====
// Each result is registered in the output register when its request is accepted.
// Throughput: one request per cycle while results are taken; the output register frees itself
// in the same cycle that its result is taken, so input and output run back to back.
// Reset: arst_n clears the debounce and press state, both flags and the output valid,
// and loads the configuration registers with their default values.
module key_debounce_press_classifier_unit #(
	parameter int COUNT_WIDTH = kdpc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          key_level,
	input  logic                          take_short,
	input  logic                          take_long,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          ready_res,
	output logic                          pressed,
	output logic                          short_press,
	output logic                          long_press,
	output logic                          short_pending,
	output logic                          long_pending,
	input  logic                          cfg_we,
	input  logic [kdpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kdpc_pkg::CFG_W-1:0]     cfg_data
);
	import kdpc_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

	logic [CFG_W-1:0] debounce_ticks_q;
	logic [CFG_W-1:0] long_ticks_q;
	logic active_low_q;

	kdpc_phase_t phase_q;
	kdpc_phase_t phase_n;
	logic [COUNT_WIDTH-1:0] hold_q;
	logic [COUNT_WIDTH-1:0] hold_n;
	logic [COUNT_WIDTH-1:0] hold_inc;
	logic short_flag_q;
	logic long_flag_q;
	logic short_set;
	logic long_set;
	logic short_flag_n;
	logic long_flag_n;
	logic got_short;
	logic got_long;
	logic rise;
	logic fall;
	logic accept;

	logic out_valid_q;
	logic ready_res_q;
	logic pressed_q;
	logic short_press_q;
	logic long_press_q;
	logic short_pending_q;
	logic long_pending_q;

	kdpc_deb_t deb;

	assign in_ready = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q <= DEBOUNCE_TICKS_RST;
			long_ticks_q <= LONG_PRESS_TICKS_RST;
			active_low_q <= ACTIVE_LOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE_TICKS: debounce_ticks_q <= cfg_data;
				REG_LONG_PRESS_TICKS: long_ticks_q <= cfg_data;
				REG_ACTIVE_LOW: active_low_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	kdpc_debounce #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_debounce (
		.clk(clk),
		.arst_n(arst_n),
		.step(accept),
		.key_level(key_level),
		.active_low(active_low_q),
		.debounce_ticks(debounce_ticks_q),
		.deb(deb)
	);

	// The previously seen debounced state always equals the registered one, so an
	// edge is a change between the registered and the updated debounced state.
	assign rise = (deb.cur == ST_RELEASED) && (deb.nxt == ST_PRESSED);
	assign fall = (deb.cur == ST_PRESSED) && (deb.nxt == ST_RELEASED);
	assign hold_inc = (hold_q == {COUNT_WIDTH{1'b1}}) ? hold_q : hold_q + 1'b1;

	always_comb begin
		phase_n = phase_q;
		hold_n = hold_q;
		short_set = 1'b0;
		long_set = 1'b0;
		if (rise) begin
			hold_n = '0;
			phase_n = PH_BEGIN;
		end else if (fall) begin
			short_set = (phase_q == PH_BEGIN);
			phase_n = PH_NONE;
		end else if (phase_q == PH_BEGIN && deb.nxt == ST_PRESSED) begin
			hold_n = hold_inc;
			if (CMP_W'(hold_inc) > CMP_W'(long_ticks_q)) begin
				phase_n = PH_LONG;
				long_set = 1'b1;
			end
		end
		got_short = take_short && (short_flag_q || short_set);
		got_long = take_long && (long_flag_q || long_set);
		short_flag_n = (short_flag_q || short_set) && !take_short;
		long_flag_n = (long_flag_q || long_set) && !take_long;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NONE;
			hold_q <= '0;
			short_flag_q <= 1'b0;
			long_flag_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase_n;
				hold_q <= hold_n;
				short_flag_q <= short_flag_n;
				long_flag_q <= long_flag_n;
			end
			if (in_ready) begin
				out_valid_q <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ready_res_q <= (deb.nxt != ST_UNINIT);
			pressed_q <= (deb.nxt == ST_PRESSED);
			short_press_q <= got_short;
			long_press_q <= got_long;
			short_pending_q <= short_flag_n;
			long_pending_q <= long_flag_n;
		end
	end

	assign out_valid = out_valid_q;
	assign ready_res = ready_res_q;
	assign pressed = pressed_q;
	assign short_press = short_press_q;
	assign long_press = long_press_q;
	assign short_pending = short_pending_q;
	assign long_pending = long_pending_q;

endmodule

// ===== sv/kdpc_debounce.sv =====
module kdpc_debounce #(
	parameter int COUNT_WIDTH = kdpc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic                      key_level,
	input  logic                      active_low,
	input  logic [kdpc_pkg::CFG_W-1:0] debounce_ticks,
	output kdpc_pkg::kdpc_deb_t       deb
);
	import kdpc_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

	kdpc_state_t raw_q;
	kdpc_state_t deb_q;
	logic [COUNT_WIDTH-1:0] stable_q;

	kdpc_state_t now_state;
	kdpc_state_t raw_n;
	kdpc_state_t deb_n;
	logic [COUNT_WIDTH-1:0] stable_n;
	logic [CMP_W-1:0] stable_ext;
	logic [CMP_W-1:0] limit_ext;

	always_comb begin
		now_state = (key_level ^ active_low) ? ST_PRESSED : ST_RELEASED;
		raw_n = now_state;
		if (raw_q != now_state) begin
			stable_n = '0;
		end else if (stable_q == {COUNT_WIDTH{1'b1}}) begin
			stable_n = stable_q;
		end else begin
			stable_n = stable_q + 1'b1;
		end
		stable_ext = CMP_W'(stable_n);
		limit_ext = CMP_W'(debounce_ticks);
		if (deb_q != now_state && stable_ext > limit_ext) begin
			deb_n = now_state;
		end else begin
			deb_n = deb_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q <= ST_UNINIT;
			deb_q <= ST_UNINIT;
			stable_q <= '0;
		end else if (step) begin
			raw_q <= raw_n;
			deb_q <= deb_n;
			stable_q <= stable_n;
		end
	end

	assign deb.cur = deb_q;
	assign deb.nxt = deb_n;

endmodule

// ===== sv/kdpc_checker.sv =====
`include "assert_macros.svh"

module kdpc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic ready_res,
	input logic pressed,
	input logic short_press,
	input logic long_press,
	input logic short_pending,
	input logic long_pending
);

	logic [5:0] res_bits;

	assign res_bits = {ready_res, pressed, short_press, long_press, short_pending, long_pending};

	// A held result must not change until it is taken.
	`ASSERT_ALWAYS(a_out_hold, clk, arst_n, (out_valid && !out_ready) |=> (out_valid && $stable(res_bits)))

	// The block takes a new request whenever its output register is free or draining.
	`ASSERT_ALWAYS(a_in_ready, clk, arst_n, in_ready == (!out_valid || out_ready))

	// No press can be seen before the debounced state exists.
	`ASSERT_NEVER(a_no_press_uninit, clk, arst_n, out_valid && !ready_res && (pressed || short_pending || long_pending))

	// A taken flag is cleared in the same request.
	`ASSERT_NEVER(a_take_clears, clk, arst_n, out_valid && ((short_press && short_pending) || (long_press && long_pending)))

endmodule

bind key_debounce_press_classifier_unit kdpc_checker u_kdpc_checker (.*);

// ===== bench/tb_key_debounce_press_classifier_unit.sv =====
module tb_key_debounce_press_classifier_unit;
	import kdpc_pkg::*;

	localparam int CW = COUNT_WIDTH_DEF;
	localparam int STALL_LIMIT = 4000;
	localparam int LONG_HOLD = 120;

	typedef struct packed {
		logic key_level;
		logic take_short;
		logic take_long;
	} tick_req_t;

	typedef struct packed {
		logic ready_res;
		logic pressed;
		logic short_press;
		logic long_press;
		logic short_pending;
		logic long_pending;
	} press_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic key_level = 1'b0;
	logic take_short = 1'b0;
	logic take_long = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic ready_res;
	logic pressed;
	logic short_press;
	logic long_press;
	logic short_pending;
	logic long_pending;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_DEBOUNCE_TICKS;
	logic [CFG_W-1:0] cfg_data = '0;

	key_debounce_press_classifier_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.key_level(key_level),
		.take_short(take_short),
		.take_long(take_long),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ready_res(ready_res),
		.pressed(pressed),
		.short_press(short_press),
		.long_press(long_press),
		.short_pending(short_pending),
		.long_pending(long_pending),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow of the block: configuration and debounce / press state.
	logic [CFG_W-1:0] m_debounce = DEBOUNCE_TICKS_RST;
	logic [CFG_W-1:0] m_long = LONG_PRESS_TICKS_RST;
	logic m_active_low = ACTIVE_LOW_RST;
	kdpc_state_t m_raw = ST_UNINIT;
	kdpc_state_t m_deb = ST_UNINIT;
	kdpc_state_t m_prev = ST_UNINIT;
	kdpc_phase_t m_phase = PH_NONE;
	logic [CW-1:0] m_stable = '0;
	logic [CW-1:0] m_hold = '0;
	logic m_short = 1'b0;
	logic m_long_flag = 1'b0;

	tick_req_t tick_q[$];
	press_result_t expected_q[$];
	tick_req_t tx_item;
	press_result_t exp_r;

	int ticks_queued = 0;
	int mismatches = 0;
	int stall_cycles = 0;
	int idle_pct = 0;
	int tx_gap = 0;
	int rx_left = 0;
	int hold_asked = 0;
	int hold_served = 0;
	logic in_fire = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Advances the shadow state by one tick and returns what the block should report.
	function automatic press_result_t classify_tick(input logic lvl, input logic ts,
			input logic tl);
		kdpc_state_t now_st;
		logic started;
		press_result_t r;
		now_st = ((lvl ^ m_active_low) != 1'b0) ? ST_PRESSED : ST_RELEASED;
		started = 1'b0;
		r = '0;
		if (m_raw != now_st) begin
			m_raw = now_st;
			m_stable = '0;
		end else begin
			m_stable = sat_inc(m_stable);
		end
		if (m_deb != now_st && m_stable > m_debounce)
			m_deb = now_st;
		if (m_prev != m_deb) begin
			if (m_prev == ST_RELEASED && m_deb == ST_PRESSED) begin
				m_hold = '0;
				m_phase = PH_BEGIN;
				started = 1'b1;
			end
			if (m_prev == ST_PRESSED && m_deb == ST_RELEASED) begin
				if (m_phase == PH_BEGIN)
					m_short = 1'b1;
				m_phase = PH_NONE;
			end
			m_prev = m_deb;
		end
		if (m_phase == PH_BEGIN && m_deb == ST_PRESSED) begin
			if (!started)
				m_hold = sat_inc(m_hold);
			if (m_hold > m_long) begin
				m_phase = PH_LONG;
				m_long_flag = 1'b1;
			end
		end
		if (ts) begin
			r.short_press = m_short;
			m_short = 1'b0;
		end
		if (tl) begin
			r.long_press = m_long_flag;
			m_long_flag = 1'b0;
		end
		r.ready_res = (m_deb != ST_UNINIT);
		r.pressed = (m_deb == ST_PRESSED);
		r.short_pending = m_short;
		r.long_pending = m_long_flag;
		return r;
	endfunction

	task automatic check_bit(input string what, input logic want, input logic got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0b, actual %0b", $time, what, want, got);
			mismatches++;
		end
	endtask

	function automatic void push_tick(input logic lvl, input logic ts, input logic tl);
		tick_req_t t;
		t.key_level = lvl;
		t.take_short = ts;
		t.take_long = tl;
		tick_q.push_back(t);
		ticks_queued++;
	endfunction

	function automatic void push_ticks(input logic lvl, input int n, input int take_pct);
		repeat (n)
			push_tick(lvl, $urandom_range(99) < take_pct, $urandom_range(99) < take_pct);
	endfunction

	function automatic void push_noise(input int n);
		repeat (n)
			push_tick($urandom_range(1), $urandom_range(1), $urandom_range(1));
	endfunction

	// A press of random length followed by a release, each sometimes preceded by a burst of noise.
	function automatic void push_press();
		logic pl;
		pl = ~m_active_low;
		if ($urandom_range(3) == 0)
			push_noise($urandom_range(4, 1));
		push_ticks(pl, $urandom_range(m_debounce + m_long + 8, 0), 20);
		if ($urandom_range(3) == 0)
			push_noise($urandom_range(4, 1));
		push_ticks(~pl, $urandom_range(m_debounce + 6, 0), 20);
	endfunction

	function automatic void push_random(input int n, input int noise_pct);
		int target;
		target = ticks_queued + n;
		while (ticks_queued < target) begin
			if ($urandom_range(99) < noise_pct)
				push_noise($urandom_range(8, 1));
			else
				push_press();
		end
	endfunction

	task automatic wait_drained();
		do @(posedge clk);
		while (tick_q.size() != 0 || in_valid || expected_q.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_W-1:0];
		case (idx)
			REG_DEBOUNCE_TICKS: m_debounce = val[CFG_W-1:0];
			REG_LONG_PRESS_TICKS: m_long = val[CFG_W-1:0];
			REG_ACTIVE_LOW: m_active_low = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(input int unsigned deb, input int unsigned lng,
			input int unsigned pol);
		wait_drained();
		write_reg(REG_DEBOUNCE_TICKS, deb);
		write_reg(REG_LONG_PRESS_TICKS, lng);
		write_reg(REG_ACTIVE_LOW, pol);
		@(posedge clk);
	endtask

	// Sender: offers the next request, holding it steady until it is taken.
	always @(negedge clk) begin
		if (in_valid && !in_fire) begin
		end else if (tx_gap > 0) begin
			tx_gap <= tx_gap - 1;
			in_valid <= 1'b0;
		end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			tx_gap <= $urandom_range(11, 0);
			in_valid <= 1'b0;
		end else if (tick_q.size() != 0) begin
			tx_item = tick_q.pop_front();
			key_level <= tx_item.key_level;
			take_short <= tx_item.take_short;
			take_long <= tx_item.take_long;
			in_valid <= 1'b1;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver: random stall bursts, plus one long hold-off when asked for.
	always @(negedge clk) begin
		if (hold_asked != hold_served) begin
			hold_served <= hold_served + 1;
			rx_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else if (rx_left > 0) begin
			rx_left <= rx_left - 1;
			out_ready <= 1'b0;
		end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			rx_left <= $urandom_range(11, 0);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			// Check before predicting, since a result always trails its request.
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result with no request outstanding", $time);
					mismatches++;
				end else begin
					exp_r = expected_q.pop_front();
					check_bit("ready_res", exp_r.ready_res, ready_res);
					check_bit("pressed", exp_r.pressed, pressed);
					check_bit("short_press", exp_r.short_press, short_press);
					check_bit("long_press", exp_r.long_press, long_press);
					check_bit("short_pending", exp_r.short_pending, short_pending);
					check_bit("long_pending", exp_r.long_pending, long_pending);
				end
			end
			if (in_valid && in_ready)
				expected_q.push_back(classify_tick(key_level, take_short, take_long));
			in_fire <= in_valid && in_ready;
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("key_debounce_press_classifier_unit regression: fail");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Default settings: three ticks of a changing key, takes with both flags clear.
		idle_pct = 20;
		push_tick(1'b0, 1'b1, 1'b1);
		push_tick(1'b1, 1'b0, 1'b0);
		push_tick(1'b0, 1'b1, 1'b0);

		// Held at start is adopted without a press, then two long presses.
		set_regs(1, 2, 1);
		push_ticks(1'b0, 3, 0);
		push_ticks(1'b1, 3, 0);
		push_ticks(1'b0, 4, 0);
		push_ticks(1'b1, 2, 0);
		push_tick(1'b1, 1'b1, 1'b0);
		push_ticks(1'b0, 5, 0);
		push_tick(1'b0, 1'b1, 1'b1);
		push_ticks(1'b1, 3, 0);

		idle_pct = 25;
		set_regs(1, 3, 1);
		push_random(130, 15);

		idle_pct = 0;
		set_regs(0, 0, 0);
		push_random(100, 15);

		idle_pct = 15;
		set_regs(3, 10, 0);
		push_random(130, 15);

		// Large settings: a debounce setting far beyond the run, so a changed
		// key is never adopted, then a long threshold of zero.
		idle_pct = 3;
		set_regs(65535, 0, 1);
		push_ticks((m_deb == ST_PRESSED) ? m_active_low : ~m_active_low, 20, 20);
		set_regs(2, 0, 0);
		push_ticks(1'b0, 6, 0);
		push_ticks(1'b1, 10, 30);
		push_ticks(1'b0, 6, 30);

		idle_pct = 30;
		set_regs(2, 6, 1);
		push_random(150, 15);
		while (tick_q.size() > 60)
			@(posedge clk);
		hold_asked++;

		idle_pct = 0;
		set_regs(0, 1, 1);
		push_random(120, 15);

		wait_drained();
		repeat (4) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("key_debounce_press_classifier_unit regression: pass");
		end else begin
			$display("key_debounce_press_classifier_unit regression: fail");
		end
		$finish;
	end

endmodule
